### hdl/rpag_pkg.sv
// Shared types, constants and helper functions for the RGBA pixel to glyph stream block.
`timescale 1ns / 1ps

package rpag_pkg;

    // Glyph table geometry.
    localparam int GRAY_LEVELS = 256;
    localparam int LEVEL_W     = $clog2(GRAY_LEVELS);

    // Configuration register widths, indexes and reset values.
    localparam int ROW_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = ROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_CHAR    = 2'd2;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 13'd100;
    localparam logic             COLOR_RST     = 1'b0;
    localparam logic [7:0]       BG_CHAR_RST   = 8'h20;

    // Request kinds.
    localparam logic REQ_PIXEL       = 1'b0;
    localparam logic REQ_GLYPH_WRITE = 1'b1;

    // Job queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       req_type;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] level_index;
        logic [7:0] glyph_char;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    // One color component split into decimal digits.
    typedef struct packed {
        logic [1:0] h;
        logic [3:0] t;
        logic [3:0] o;
    } t_dec;

    // Everything the back needs to print one pixel.
    typedef struct packed {
        logic       color;
        logic       transp;
        logic       line_end;
        logic [7:0] ch;
        t_dec       red;
        t_dec       green;
        t_dec       blue;
    } t_job;

    // Hundreds by compare, tens by reciprocal multiply, ones by subtraction.
    function automatic t_dec dec3(input logic [7:0] v);
        t_dec        d;
        logic [7:0]  rem;
        logic [15:0] prod;
        if (v >= 8'd200) begin
            d.h = 2'd2;
            rem = v - 8'd200;
        end else if (v >= 8'd100) begin
            d.h = 2'd1;
            rem = v - 8'd100;
        end else begin
            d.h = 2'd0;
            rem = v;
        end
        prod = 16'(rem) * 16'd205;
        d.t  = prod[14:11];
        d.o  = 4'(rem - 8'(d.t) * 8'd10);
        return d;
    endfunction

endpackage

### hdl/rgba_pixel_to_ascii_glyph_stream.sv
// Top level of the RGBA pixel to ASCII glyph text stream converter.
`timescale 1ns / 1ps

// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) takes one beat per item: either a
// pixel to render or a write into the 256-entry glyph table, selected by req_type.
// The output channel (o_out_valid, i_out_stall, o_out_data) carries one text byte per
// beat; last_of_run marks the final byte caused by a pixel. Table writes cause no bytes.
// The first byte of a pixel passes the stage-one register and the job queue before it
// reaches the output register. The byte sequencer emits one byte per cycle while the
// receiver does not stall; a pixel has 1 or 2 bytes in plain mode, up to 25 in color
// mode at a row end. Table writes and plain pixels can be accepted every cycle while the
// queue has room; a four-entry job queue between the luma/glyph front end and the
// sequencer absorbs bursts. A glyph entry must be written before any pixel maps to it.
// When the receiver stalls, the output byte holds and the queue fills. o_in_stall rises
// when it is full, or one short of full while a glyph read is pending, and during reset.
// Reset (synchronous, active low) empties the queue, restarts the column count and loads
// row_width 100, color_mode 0 and background_char space. The glyph table is not cleared.
// Configuration writes through i_cfg_we/i_cfg_index/i_cfg_data take effect on the next
// accepted pixel and are expected only while the block is idle.
module rgba_pixel_to_ascii_glyph_stream #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rpag_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rpag_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [rpag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rpag_pkg::CFG_W-1:0]       i_cfg_data
);
    import rpag_pkg::*;

    // Configuration registers.
    logic [ROW_W-1:0]  r_row_width;
    logic              r_color_mode;
    logic [7:0]        r_bg_char;

    // Front to queue to back.
    logic              q_push;
    t_job              q_job_in;
    t_job              q_head;
    logic              q_empty;
    logic              q_pop;
    logic [QCNT_W-1:0] q_free;

    // Unknown register indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= ROW_WIDTH_RST;
            r_color_mode <= COLOR_RST;
            r_bg_char    <= BG_CHAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_WIDTH:  r_row_width  <= i_cfg_data;
                CFG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                CFG_BG_CHAR:    r_bg_char    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: glyph table, luma, transparency and line-end decision.
    rpag_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_row_width  (r_row_width),
        .i_color_mode (r_color_mode),
        .i_bg_char    (r_bg_char),
        .i_q_free     (q_free),
        .o_push       (q_push),
        .o_job        (q_job_in)
    );

    // Decouples pixel acceptance from byte output.
    rpag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_free  (q_free)
    );

    // Back end: expands each job into escape sequence, digits, glyph and line end.
    rpag_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_free != '0))
        else $error("job pushed into a full queue");

    // An accepted pixel becomes exactly one job on the next cycle.
    a_pixel_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.req_type == REQ_PIXEL) |=> q_push)
        else $error("accepted pixel produced no job");

    // A table write never produces a job.
    a_write_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.req_type == REQ_GLYPH_WRITE) |=> !q_push)
        else $error("glyph table write produced a job");

    // The sequencer only retires a job while one is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job retired from an empty queue");

endmodule

### hdl/rpag_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module rpag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rpag_front.sv
// Front end: accepts beats, writes the glyph table, computes luma and row position.
`timescale 1ns / 1ps

module rpag_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rpag_pkg::t_in                 i_in_data,
    input  logic [rpag_pkg::ROW_W-1:0]    i_row_width,
    input  logic                          i_color_mode,
    input  logic [7:0]                    i_bg_char,
    input  logic [rpag_pkg::QCNT_W-1:0]   i_q_free,
    output logic                          o_push,
    output rpag_pkg::t_job                o_job
);
    import rpag_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > ROW_W) ? CW + 1 : ROW_W;

    logic          accept;
    logic          pix_accept;
    logic          wr_accept;
    logic [15:0]   luma_sum;
    logic [7:0]    luma;
    logic [EW-1:0] rw_ext;
    logic [EW-1:0] eff_width;
    logic [EW-1:0] count_inc;
    logic          line_end;
    logic [7:0]    ram_rdata;

    logic          r_s1_valid;
    t_job          r_s1_job;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;

    // One entry is reserved for the pixel already waiting on its glyph read.
    assign o_in_stall = !i_rst_n ||
        (r_s1_valid ? (i_q_free < QCNT_W'(2)) : (i_q_free == '0));

    assign accept     = i_in_valid && !o_in_stall;
    assign pix_accept = accept && (i_in_data.req_type == REQ_PIXEL);
    assign wr_accept  = accept && (i_in_data.req_type == REQ_GLYPH_WRITE);

    assign luma_sum = 16'(i_in_data.red) * 16'd77 + 16'(i_in_data.green) * 16'd150
                    + 16'(i_in_data.blue) * 16'd29;
    assign luma     = luma_sum[15:8];

    // Row width of zero acts as one, and widths above the maximum saturate.
    always_comb begin
        rw_ext = EW'(i_row_width);
        if (rw_ext == '0) begin
            eff_width = EW'(1);
        end else if (rw_ext > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = rw_ext;
        end
        count_inc = EW'(r_col) + EW'(1);
        line_end  = (count_inc >= eff_width);
        n_col     = line_end ? '0 : CW'(count_inc);
    end

    rpag_ram #(
        .WIDTH (8),
        .DEPTH (GRAY_LEVELS)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (wr_accept),
        .i_waddr (i_in_data.level_index),
        .i_wdata (i_in_data.glyph_char),
        .i_re    (pix_accept),
        .i_raddr (luma),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= '0;
        end else begin
            r_s1_valid <= pix_accept;
            if (pix_accept) begin
                r_col <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_s1_job.color    <= i_color_mode;
            r_s1_job.transp   <= (i_in_data.alpha < 8'd128);
            r_s1_job.line_end <= line_end;
            r_s1_job.ch       <= i_bg_char;
            r_s1_job.red      <= dec3(i_in_data.red);
            r_s1_job.green    <= dec3(i_in_data.green);
            r_s1_job.blue     <= dec3(i_in_data.blue);
        end
    end

    always_comb begin
        o_job = r_s1_job;
        if (!r_s1_job.transp) begin
            o_job.ch = ram_rdata;
        end
    end

    assign o_push = r_s1_valid;

endmodule

### hdl/rpag_queue.sv
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module rpag_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  rpag_pkg::t_job                i_job,
    input  logic                          i_pop,
    output rpag_pkg::t_job                o_head,
    output logic                          o_empty,
    output logic [rpag_pkg::QCNT_W-1:0]   o_free
);
    import rpag_pkg::*;

    t_job              r_slots [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    assign o_head  = r_slots[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_free  = QCNT_W'(QDEPTH) - r_count;

endmodule

### hdl/rpag_back.sv
// Back end: walks the byte sequence of each job and drives the output register.
`timescale 1ns / 1ps

module rpag_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpag_pkg::t_job i_head,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rpag_pkg::t_out o_out_data
);
    import rpag_pkg::*;

    // Positions in the byte sequence of one pixel.
    localparam logic [4:0] SL_ESC    = 5'd0;
    localparam logic [4:0] SL_LBR    = 5'd1;
    localparam logic [4:0] SL_3      = 5'd2;
    localparam logic [4:0] SL_8      = 5'd3;
    localparam logic [4:0] SL_SEMI1  = 5'd4;
    localparam logic [4:0] SL_2      = 5'd5;
    localparam logic [4:0] SL_SEMI2  = 5'd6;
    localparam logic [4:0] SL_R_H    = 5'd7;
    localparam logic [4:0] SL_R_T    = 5'd8;
    localparam logic [4:0] SL_R_O    = 5'd9;
    localparam logic [4:0] SL_SEMI3  = 5'd10;
    localparam logic [4:0] SL_G_H    = 5'd11;
    localparam logic [4:0] SL_G_T    = 5'd12;
    localparam logic [4:0] SL_G_O    = 5'd13;
    localparam logic [4:0] SL_SEMI4  = 5'd14;
    localparam logic [4:0] SL_B_H    = 5'd15;
    localparam logic [4:0] SL_B_T    = 5'd16;
    localparam logic [4:0] SL_B_O    = 5'd17;
    localparam logic [4:0] SL_M      = 5'd18;
    localparam logic [4:0] SL_CHAR   = 5'd19;
    localparam logic [4:0] SL_LE_ESC = 5'd20;
    localparam logic [4:0] SL_LE_LBR = 5'd21;
    localparam logic [4:0] SL_LE_0   = 5'd22;
    localparam logic [4:0] SL_LE_M   = 5'd23;
    localparam logic [4:0] SL_NL     = 5'd24;
    localparam logic [4:0] SL_TR_ESC = 5'd25;
    localparam logic [4:0] SL_TR_LBR = 5'd26;
    localparam logic [4:0] SL_TR_0   = 5'd27;
    localparam logic [4:0] SL_TR_M   = 5'd28;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_NL   = 8'h0A;

    // First digit slot of a component: hundreds, tens or ones, no leading zeros.
    function automatic logic [4:0] first_digit(input t_dec d, input logic [4:0] base);
        logic [4:0] s;
        if (d.h != 2'd0) begin
            s = base;
        end else if (d.t != 4'd0) begin
            s = base + 5'd1;
        end else begin
            s = base + 5'd2;
        end
        return s;
    endfunction

    logic       r_mid;
    logic [4:0] r_slot;
    logic       r_out_valid;
    t_out       r_out;

    logic [4:0] cur;
    logic [4:0] nxt;
    logic       done;
    logic [7:0] byte_val;
    logic       load;

    always_comb begin
        if (r_mid) begin
            cur = r_slot;
        end else if (i_head.color) begin
            cur = i_head.transp ? SL_TR_ESC : SL_ESC;
        end else begin
            cur = SL_CHAR;
        end
    end

    always_comb begin
        nxt      = cur + 5'd1;
        done     = 1'b0;
        byte_val = CH_0;
        unique case (cur)
            SL_ESC, SL_LE_ESC, SL_TR_ESC: byte_val = CH_ESC;
            SL_LBR, SL_LE_LBR, SL_TR_LBR: byte_val = CH_LBR;
            SL_3:      byte_val = CH_3;
            SL_8:      byte_val = CH_8;
            SL_2:      byte_val = CH_2;
            SL_SEMI1:  byte_val = CH_SEMI;
            SL_SEMI2: begin
                byte_val = CH_SEMI;
                nxt      = first_digit(i_head.red, SL_R_H);
            end
            SL_R_H:    byte_val = CH_0 + {6'd0, i_head.red.h};
            SL_R_T:    byte_val = CH_0 + {4'd0, i_head.red.t};
            SL_R_O:    byte_val = CH_0 + {4'd0, i_head.red.o};
            SL_SEMI3: begin
                byte_val = CH_SEMI;
                nxt      = first_digit(i_head.green, SL_G_H);
            end
            SL_G_H:    byte_val = CH_0 + {6'd0, i_head.green.h};
            SL_G_T:    byte_val = CH_0 + {4'd0, i_head.green.t};
            SL_G_O:    byte_val = CH_0 + {4'd0, i_head.green.o};
            SL_SEMI4: begin
                byte_val = CH_SEMI;
                nxt      = first_digit(i_head.blue, SL_B_H);
            end
            SL_B_H:    byte_val = CH_0 + {6'd0, i_head.blue.h};
            SL_B_T:    byte_val = CH_0 + {4'd0, i_head.blue.t};
            SL_B_O:    byte_val = CH_0 + {4'd0, i_head.blue.o};
            SL_M, SL_LE_M: byte_val = CH_M;
            SL_CHAR: begin
                byte_val = i_head.ch;
                nxt      = i_head.color ? SL_LE_ESC : SL_NL;
                done     = !i_head.line_end;
            end
            SL_LE_0, SL_TR_0: byte_val = CH_0;
            SL_NL: begin
                byte_val = CH_NL;
                done     = 1'b1;
            end
            SL_TR_M: begin
                byte_val = CH_M;
                nxt      = SL_CHAR;
            end
            default: begin
                byte_val = CH_0;
                done     = 1'b1;
            end
        endcase
    end

    assign load  = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_pop = load && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_slot      <= SL_ESC;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mid       <= !done;
                r_slot      <= nxt;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte    <= byte_val;
            r_out.last_of_run <= done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
